// ----- rtl/core/mrq_pkg.sv -----
`default_nettype none

package mrq_pkg;

  localparam int unsigned MsgW     = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CapReset = 16;
  localparam int unsigned DepthDef = 16;

  localparam logic [KindW-1:0] KIND_SEND = 2'd0;
  localparam logic [KindW-1:0] KIND_JAM  = 2'd1;
  localparam logic [KindW-1:0] KIND_RECV = 2'd2;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_JAM,
    OP_RECV,
    OP_NOP
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [MsgW-1:0] msg;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/mrq_front.sv -----
`default_nettype none

module mrq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mrq_pkg::KindW-1:0]   kind_i,
  input  logic [mrq_pkg::MsgW-1:0]    message_in_i,
  input  mrq_pkg::qstat_t             qstat_i,
  output logic                        push_o,
  output mrq_pkg::item_t              item_o
);

  logic           valid_q, valid_d;
  mrq_pkg::item_t item_q;
  mrq_pkg::op_e   op;
  logic           accept;

  always_comb begin
    case (kind_i)
      mrq_pkg::KIND_SEND: op = mrq_pkg::OP_SEND;
      mrq_pkg::KIND_JAM:  op = mrq_pkg::OP_JAM;
      mrq_pkg::KIND_RECV: op = mrq_pkg::OP_RECV;
      default:            op = mrq_pkg::OP_NOP;
    endcase
  end

  assign push_o     = valid_q && !qstat_i.full;
  assign in_stall_o = valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op  <= op;
      item_q.msg <= message_in_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrq_queue.sv -----
`default_nettype none

module mrq_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrq_pkg::item_t  item_i,
  input  logic            pop_i,
  output mrq_pkg::qstat_t qstat_o,
  output mrq_pkg::item_t  item_o
);

  mrq_pkg::item_t ent_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;

  assign qstat_o.valid = (cnt_q != 2'd0);
  assign qstat_o.full  = (cnt_q == 2'd2);
  assign item_o        = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrq_rem.sv -----
`default_nettype none

module mrq_rem #(
  parameter int unsigned AW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [AW-1:0]             dividend_i,
  input  logic [mrq_pkg::CntW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [AW-1:0]             rem_o
);

  localparam int unsigned CW  = mrq_pkg::CntW;
  localparam int unsigned StW = (AW > 1) ? $clog2(AW) : 1;

  logic            busy_q;
  logic [StW-1:0]  step_q;
  logic [AW-1:0]   div_q;
  logic [CW-1:0]   dsr_q;
  logic [CW-1:0]   r_q, r_d;
  logic [CW:0]     trial;

  assign trial  = {r_q, div_q[AW-1]};
  assign r_d    = (trial >= {1'b0, dsr_q}) ? CW'(trial - {1'b0, dsr_q}) : CW'(trial);
  assign busy_o = busy_q;
  assign done_o = busy_q && (step_q == StW'(AW - 1));
  assign rem_o  = AW'(r_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + StW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      dsr_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      div_q <= div_q << 1;
      r_q   <= r_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrq_back.sv -----
`default_nettype none

module mrq_back #(
  parameter int unsigned DEPTH = mrq_pkg::DepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mrq_pkg::qstat_t           qstat_i,
  input  mrq_pkg::item_t            item_i,
  output logic                      pop_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mrq_pkg::CntW-1:0]  capacity_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mrq_pkg::StatW-1:0] status_o,
  output logic [mrq_pkg::MsgW-1:0]  message_out_o,
  output logic [mrq_pkg::CntW-1:0]  fill_count_o
);

  localparam int unsigned CW = mrq_pkg::CntW;
  localparam int unsigned MW = mrq_pkg::MsgW;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned CapRst =
    (mrq_pkg::CapReset > DEPTH) ? DEPTH : mrq_pkg::CapReset;

  localparam logic S_RUN  = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state_q, state_d;
  logic [CW-1:0]     cap_q, cap_new;
  logic [AW-1:0]     raw_q, raw_d;
  logic [AW-1:0]     red_q, red_d;
  logic [CW-1:0]     held_q, held_d;
  logic [CW-1:0]     pend_fill_q;

  logic              out_valid_q, out_valid_d;
  mrq_pkg::status_e  out_status_q, out_status_d;
  logic [MW-1:0]     out_msg_q, out_msg_d;
  logic [CW-1:0]     out_fill_q, out_fill_d;

  logic [MW-1:0]     mem_q [DEPTH];
  logic [MW-1:0]     rdata_q;
  logic              we, re;
  logic [AW-1:0]     waddr;

  logic              rem_busy, rem_done, cfg_fire, exec, out_free;
  logic [AW-1:0]     rem_val;
  logic              full, empty;
  logic [SW-1:0]     cap_s, head_s, sum_s, tail_s, jam_s, inc_s, nxt_s;

  assign out_free = !out_valid_q || !out_stall_i;
  assign exec     = (state_q == S_RUN) && qstat_i.valid && !rem_busy && out_free;
  assign pop_o    = exec;

  assign cfg_ready_o = !rem_busy && (state_q == S_RUN) && !exec && !out_valid_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (capacity_i == '0) begin
      cap_new = CW'(1);
    end else if (int'(capacity_i) > int'(DEPTH)) begin
      cap_new = CW'(DEPTH);
    end else begin
      cap_new = capacity_i;
    end
  end

  mrq_rem #(
    .AW(AW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_fire),
    .dividend_i (raw_q),
    .divisor_i  (cap_new),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign cap_s  = SW'(cap_q);
  assign head_s = SW'(red_q);
  assign sum_s  = head_s + SW'(held_q);
  assign tail_s = (sum_s >= cap_s) ? (sum_s - cap_s) : sum_s;
  assign jam_s  = (head_s == '0) ? (cap_s - SW'(1)) : (head_s - SW'(1));
  assign inc_s  = head_s + SW'(1);
  assign nxt_s  = (inc_s == cap_s) ? '0 : inc_s;
  assign full   = (held_q >= cap_q);
  assign empty  = (held_q == '0);

  always_comb begin
    state_d      = state_q;
    raw_d        = raw_q;
    red_d        = red_q;
    held_d       = held_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = AW'(tail_s);
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_msg_d    = out_msg_q;
    out_fill_d   = out_fill_q;

    if (rem_done) begin
      red_d = rem_val;
    end

    if (state_q == S_READ) begin
      state_d      = S_RUN;
      out_valid_d  = 1'b1;
      out_status_d = mrq_pkg::ST_DONE;
      out_msg_d    = rdata_q;
      out_fill_d   = pend_fill_q;
    end else if (exec) begin
      out_status_d = mrq_pkg::ST_DONE;
      out_msg_d    = '0;
      case (item_i.op)
        mrq_pkg::OP_SEND: begin
          if (full) begin
            out_status_d = mrq_pkg::ST_FULL;
          end else begin
            we     = 1'b1;
            waddr  = AW'(tail_s);
            raw_d  = red_q;
            held_d = held_q + CW'(1);
          end
        end
        mrq_pkg::OP_JAM: begin
          if (full) begin
            out_status_d = mrq_pkg::ST_FULL;
          end else begin
            we     = 1'b1;
            waddr  = AW'(jam_s);
            raw_d  = AW'(jam_s);
            red_d  = AW'(jam_s);
            held_d = held_q + CW'(1);
          end
        end
        mrq_pkg::OP_RECV: begin
          if (empty) begin
            out_status_d = mrq_pkg::ST_EMPTY;
          end else begin
            re      = 1'b1;
            raw_d   = AW'(nxt_s);
            red_d   = AW'(nxt_s);
            held_d  = held_q - CW'(1);
            state_d = S_READ;
          end
        end
        default: begin
        end
      endcase
      out_fill_d = held_d;
      if (state_d == S_RUN) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cap_q       <= CW'(CapRst);
      raw_q       <= '0;
      red_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raw_q       <= raw_d;
      red_q       <= red_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        cap_q <= cap_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_msg_q    <= out_msg_d;
    out_fill_q   <= out_fill_d;
    if (exec) begin
      pend_fill_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= item_i.msg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[red_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign message_out_o = out_msg_q;
  assign fill_count_o  = out_fill_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(held_q) <= int'(DEPTH))
    else $error("held count above depth");

  a_head_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rem_busy |-> (SW'(red_q) < SW'(cap_q)))
    else $error("head not reduced by capacity");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != mrq_pkg::ST_DONE) |-> (out_msg_q == '0))
    else $error("refused beat carries a message");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == mrq_pkg::ST_FULL) |-> (out_fill_q >= cap_q))
    else $error("full status below capacity");

  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q && !rem_busy)
    else $error("read slot overlaps pending beat");

endmodule

`default_nettype wire

// ----- rtl/core/message_ring_queue_with_jam.sv -----
// Channel | Direction | Handshake               | Beat
// in      | sink      | in_valid_i / in_stall_o  | kind_i, message_in_i
// out     | source    | out_valid_o / out_stall_i| status_o, message_out_o, fill_count_o
// cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_capacity_i
//
// A beat passes an input register, a two-entry queue and the executing stage.
// Send, jam, no-op and refused beats leave that stage directly; a receive also passes a read state.
// A capacity write reduces the head index one index bit per cycle; the executing
// stage holds until it finishes.
// Reset clears head and fill count and sets capacity to 16, or to DEPTH if smaller; slots have no reset.
// A stalled result holds the executing stage; the queue keeps taking beats until both entries are full.
`default_nettype none

module message_ring_queue_with_jam #(
  parameter int unsigned DEPTH = mrq_pkg::DepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mrq_pkg::KindW-1:0]   kind_i,
  input  logic [mrq_pkg::MsgW-1:0]    message_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrq_pkg::StatW-1:0]   status_o,
  output logic [mrq_pkg::MsgW-1:0]    message_out_o,
  output logic [mrq_pkg::CntW-1:0]    fill_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mrq_pkg::CntW-1:0]    cfg_capacity_i
);

  mrq_pkg::qstat_t qstat;
  mrq_pkg::item_t  front_item, queue_item;
  logic            push, pop;

  mrq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .message_in_i (message_in_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .item_o       (front_item)
  );

  mrq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .qstat_o (qstat),
    .item_o  (queue_item)
  );

  mrq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .item_i        (queue_item),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .capacity_i    (cfg_capacity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .message_out_o (message_out_o),
    .fill_count_o  (fill_count_o)
  );

endmodule

`default_nettype wire
